FILE: hdl/x86ild_pkg.sv
package x86ild_pkg;

    typedef enum logic [2:0] {
        KIND_NONE  = 3'd0,
        KIND_MODRM = 3'd1,
        KIND_IMM   = 3'd2,
        KIND_ADDR  = 3'd3,
        KIND_REL16 = 3'd4,
        KIND_FAR   = 3'd5,
        KIND_REL8  = 3'd6,
        KIND_UNDEF = 3'd7
    } t_kind;

    typedef struct packed {
        t_kind kind;
        logic  wide;
    } t_class;

    // One instruction as handed from the front to the back; bytes not received read as zero
    typedef struct packed {
        logic [15:0]     start;
        logic [5:0][7:0] bytes;
        logic [2:0]      len;
        t_kind           kind;
        logic            wide;
        logic            trunc;
        logic            last;
    } t_instr;

    typedef struct packed {
        logic [15:0] instr_offset;
        logic [7:0]  opcode;
        logic [7:0]  modrm_byte;
        logic        has_modrm;
        logic [15:0] displacement;
        logic [15:0] immediate;
        logic [15:0] segment_word;
        logic [2:0]  instr_length;
        t_kind       operand_kind;
        logic [15:0] branch_target;
        logic        truncated;
        logic        last;
    } t_result;

    localparam int QUEUE_DEPTH    = 4;
    localparam int QUEUE_PTR_BITS = 2;
    localparam int QUEUE_CNT_BITS = 3;

    localparam logic [7:0] OP_GRP1_IMM8   = 8'h80;
    localparam logic [7:0] OP_GRP1_IMM16  = 8'h81;
    localparam logic [7:0] OP_GRP1_IMM8B  = 8'h82;
    localparam logic [7:0] OP_GRP1_SIMM8  = 8'h83;
    localparam logic [7:0] OP_MOV_RM8     = 8'hC6;
    localparam logic [7:0] OP_MOV_RM16    = 8'hC7;
    localparam logic [7:0] OP_GRP3_RM8    = 8'hF6;
    localparam logic [7:0] OP_GRP3_RM16   = 8'hF7;

    function automatic t_class classify(input logic [7:0] op);
        t_class c;
        c.kind = KIND_NONE;
        c.wide = 1'b0;
        if (op < 8'h40) begin
            case (op[2:0])
                3'd0, 3'd1, 3'd2, 3'd3: c.kind = KIND_MODRM;
                3'd4: c.kind = KIND_IMM;
                3'd5: begin
                    c.kind = KIND_IMM;
                    c.wide = 1'b1;
                end
                default: c.kind = KIND_NONE;
            endcase
        end else if (op < 8'h60) begin
            c.kind = KIND_NONE;
        end else if (op < 8'h70) begin
            c.kind = KIND_UNDEF;
        end else if (op < 8'h80) begin
            c.kind = KIND_REL8;
        end else if (op < 8'h90) begin
            c.kind = KIND_MODRM;
        end else if (op == 8'h9A) begin
            c.kind = KIND_FAR;
        end else if (op < 8'hA0) begin
            c.kind = KIND_NONE;
        end else if (op < 8'hA4) begin
            c.kind = KIND_ADDR;
        end else if (op == 8'hA8) begin
            c.kind = KIND_IMM;
        end else if (op == 8'hA9) begin
            c.kind = KIND_IMM;
            c.wide = 1'b1;
        end else if (op < 8'hB0) begin
            c.kind = KIND_NONE;
        end else if (op < 8'hB8) begin
            c.kind = KIND_IMM;
        end else if (op < 8'hC0) begin
            c.kind = KIND_IMM;
            c.wide = 1'b1;
        end else begin
            case (op)
                8'hC0, 8'hC1, 8'hC8, 8'hC9, 8'hF1: c.kind = KIND_UNDEF;
                8'hC2, 8'hCA: begin
                    c.kind = KIND_IMM;
                    c.wide = 1'b1;
                end
                8'hCD, 8'hD4, 8'hD5, 8'hE4, 8'hE5, 8'hE6, 8'hE7: c.kind = KIND_IMM;
                8'hE8, 8'hE9: c.kind = KIND_REL16;
                8'hEA: c.kind = KIND_FAR;
                8'hEB, 8'hE0, 8'hE1, 8'hE2, 8'hE3: c.kind = KIND_REL8;
                8'hF6, 8'hF7, 8'hFE, 8'hFF,
                8'hC4, 8'hC5, 8'hC6, 8'hC7,
                8'hD0, 8'hD1, 8'hD2, 8'hD3,
                8'hD8, 8'hD9, 8'hDA, 8'hDB, 8'hDC, 8'hDD, 8'hDE, 8'hDF:
                    c.kind = KIND_MODRM;
                default: c.kind = KIND_NONE;
            endcase
        end
        return c;
    endfunction

    function automatic logic [2:0] need_len(input t_kind kind, input logic wide);
        logic [2:0] n;
        case (kind)
            KIND_MODRM: n = 3'd2;
            KIND_IMM:   n = wide ? 3'd3 : 3'd2;
            KIND_ADDR,
            KIND_REL16: n = 3'd3;
            KIND_FAR:   n = 3'd5;
            KIND_REL8:  n = 3'd2;
            default:    n = 3'd1;
        endcase
        return n;
    endfunction

    function automatic logic [1:0] disp_len(input logic [7:0] modrm);
        logic [1:0] n;
        case (modrm[7:6])
            2'd0:    n = (modrm[2:0] == 3'd6) ? 2'd2 : 2'd0;
            2'd1:    n = 2'd1;
            2'd2:    n = 2'd2;
            default: n = 2'd0;
        endcase
        return n;
    endfunction

    function automatic logic [1:0] group_imm_len(input logic [7:0] op, input logic [7:0] modrm);
        logic [1:0] n;
        case (op)
            OP_GRP1_IMM8, OP_GRP1_IMM8B, OP_GRP1_SIMM8, OP_MOV_RM8: n = 2'd1;
            OP_GRP1_IMM16, OP_MOV_RM16: n = 2'd2;
            OP_GRP3_RM8:  n = (modrm[5:3] < 3'd2) ? 2'd1 : 2'd0;
            OP_GRP3_RM16: n = (modrm[5:3] < 3'd2) ? 2'd2 : 2'd0;
            default:      n = 2'd0;
        endcase
        return n;
    endfunction

endpackage

FILE: hdl/x86ild_front.sv
module x86ild_front #(
    parameter int OFFSET_BITS = 16
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_push,
    input  logic [7:0]          i_code_byte,
    input  logic                i_end_of_code,
    input  logic                i_q_full,
    output logic                o_q_push,
    output x86ild_pkg::t_instr  o_instr
);
    import x86ild_pkg::*;

    localparam int BUF_DEPTH = 5;

    logic [OFFSET_BITS-1:0] r_offset;
    logic [7:0]             r_buf [BUF_DEPTH];
    logic [2:0]             r_count;
    logic [2:0]             r_need;
    t_kind                  r_kind;
    logic                   r_wide;
    logic [15:0]            r_start;

    logic       accept;
    logic       first;
    t_class     cls;
    t_kind      n_kind;
    logic       n_wide;
    logic [2:0] n_need;
    logic [2:0] n_count;
    logic [15:0] n_start;
    logic       done;

    assign accept = i_push && !i_q_full;
    assign first  = (r_count == 3'd0);
    assign cls    = classify(i_code_byte);

    always_comb begin
        if (first) begin
            n_kind = cls.kind;
            n_wide = cls.wide;
            n_need = need_len(cls.kind, cls.wide);
        end else begin
            n_kind = r_kind;
            n_wide = r_wide;
            n_need = r_need;
            // second byte of a ModRM form settles the full length
            if (r_count == 3'd1 && r_kind == KIND_MODRM) begin
                n_need = 3'd2 + {1'b0, disp_len(i_code_byte)}
                       + {1'b0, group_imm_len(r_buf[0], i_code_byte)};
            end
        end
    end

    assign n_count = r_count + 3'd1;
    assign n_start = first ? r_offset[15:0] : r_start;
    assign done    = (n_count >= n_need) || i_end_of_code;

    always_comb begin
        for (int i = 0; i < BUF_DEPTH; i++) begin
            if (3'(i) < r_count) begin
                o_instr.bytes[i] = r_buf[i];
            end else if (3'(i) == r_count) begin
                o_instr.bytes[i] = i_code_byte;
            end else begin
                o_instr.bytes[i] = 8'h00;
            end
        end
        o_instr.bytes[5] = (r_count == 3'd5) ? i_code_byte : 8'h00;
        o_instr.start    = n_start;
        o_instr.len      = n_count;
        o_instr.kind     = n_kind;
        o_instr.wide     = n_wide;
        o_instr.trunc    = (n_count < n_need);
        o_instr.last     = i_end_of_code;
    end

    assign o_q_push = accept && done;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_offset <= '0;
            r_count  <= 3'd0;
            r_need   <= 3'd0;
            r_kind   <= KIND_NONE;
            r_wide   <= 1'b0;
        end else if (accept) begin
            r_offset <= i_end_of_code ? '0 : r_offset + 1'b1;
            r_count  <= done ? 3'd0 : n_count;
            r_need   <= done ? 3'd0 : n_need;
            r_kind   <= n_kind;
            r_wide   <= n_wide;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_start <= n_start;
            if (r_count < 3'(BUF_DEPTH)) begin
                r_buf[r_count] <= i_code_byte;
            end
        end
    end

    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count < 3'(BUF_DEPTH + 1))
        else $error("front byte count out of range");

    a_len_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_q_push |-> (o_instr.len != 3'd0 && o_instr.len <= 3'd6))
        else $error("emitted word has bad length");

    a_trunc_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_q_push && o_instr.trunc) |-> o_instr.last)
        else $error("truncated word without end of code");

endmodule

FILE: hdl/x86ild_queue.sv
module x86ild_queue (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_push,
    input  x86ild_pkg::t_instr i_data,
    output logic               o_full,
    input  logic               i_pop,
    output x86ild_pkg::t_instr o_data,
    output logic               o_empty
);
    import x86ild_pkg::*;

    t_instr                    r_mem [QUEUE_DEPTH];
    logic [QUEUE_PTR_BITS-1:0] r_wr_ptr;
    logic [QUEUE_PTR_BITS-1:0] r_rd_ptr;
    logic [QUEUE_CNT_BITS-1:0] r_count;

    logic do_push;
    logic do_pop;

    assign o_full  = (r_count == QUEUE_CNT_BITS'(QUEUE_DEPTH));
    assign o_empty = (r_count == '0);
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;
    assign o_data  = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (do_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            case ({do_push, do_pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    a_count_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= QUEUE_CNT_BITS'(QUEUE_DEPTH))
        else $error("queue overfilled");

    a_ptr_gap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_wr_ptr - r_rd_ptr) == r_count[QUEUE_PTR_BITS-1:0])
        else $error("queue pointers disagree with count");

endmodule

FILE: hdl/x86ild_back.sv
module x86ild_back (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  x86ild_pkg::t_instr  i_head,
    input  logic                i_q_empty,
    output logic                o_q_pop,
    input  logic                i_pop,
    output logic                o_empty,
    output x86ild_pkg::t_result o_result
);
    import x86ild_pkg::*;

    function automatic logic [15:0] sext8(input logic [7:0] v);
        return {{8{v[7]}}, v};
    endfunction

    logic    r_valid;
    t_result r_result;
    t_result n_result;

    logic [7:0]  op;
    logic [1:0]  dl;
    logic [1:0]  gl;
    logic [2:0]  imm_pos;
    logic [2:0]  imm_pos_hi;
    logic        take;

    assign op         = i_head.bytes[0];
    assign dl         = disp_len(i_head.bytes[1]);
    assign gl         = group_imm_len(op, i_head.bytes[1]);
    assign imm_pos    = 3'd2 + {1'b0, dl};
    assign imm_pos_hi = imm_pos + 3'd1;

    always_comb begin
        n_result              = '0;
        n_result.instr_offset = i_head.start;
        n_result.opcode       = op;
        n_result.instr_length = i_head.len;
        n_result.operand_kind = i_head.kind;
        n_result.truncated    = i_head.trunc;
        n_result.last         = i_head.last;
        case (i_head.kind)
            KIND_MODRM: begin
                if (i_head.len >= 3'd2) begin
                    n_result.modrm_byte = i_head.bytes[1];
                    n_result.has_modrm  = 1'b1;
                    case (dl)
                        2'd1:    n_result.displacement = sext8(i_head.bytes[2]);
                        2'd2:    n_result.displacement = {i_head.bytes[3], i_head.bytes[2]};
                        default: n_result.displacement = 16'h0000;
                    endcase
                    // group immediate sits after the displacement, 0x83 included
                    case (gl)
                        2'd1:    n_result.immediate = {8'h00, i_head.bytes[imm_pos]};
                        2'd2:    n_result.immediate = {i_head.bytes[imm_pos_hi],
                                                       i_head.bytes[imm_pos]};
                        default: n_result.immediate = 16'h0000;
                    endcase
                end
            end
            KIND_IMM: begin
                n_result.immediate = i_head.wide ? {i_head.bytes[2], i_head.bytes[1]}
                                                 : {8'h00, i_head.bytes[1]};
            end
            KIND_ADDR: begin
                n_result.immediate = {i_head.bytes[2], i_head.bytes[1]};
            end
            KIND_REL16: begin
                n_result.displacement = {i_head.bytes[2], i_head.bytes[1]};
            end
            KIND_FAR: begin
                n_result.immediate    = {i_head.bytes[2], i_head.bytes[1]};
                n_result.segment_word = {i_head.bytes[4], i_head.bytes[3]};
            end
            KIND_REL8: begin
                n_result.displacement = sext8(i_head.bytes[1]);
            end
            default: begin
                n_result.immediate = 16'h0000;
            end
        endcase
        if ((i_head.kind == KIND_REL16 || i_head.kind == KIND_REL8) && !i_head.trunc) begin
            n_result.branch_target = i_head.start + {13'd0, i_head.len}
                                   + n_result.displacement;
        end
    end

    // refill the output register when it is free or being drained
    assign take     = !i_q_empty && (!r_valid || i_pop);
    assign o_q_pop  = take;
    assign o_empty  = !r_valid;
    assign o_result = r_result;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (take) begin
            r_valid <= 1'b1;
        end else if (i_pop) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (take) begin
            r_result <= n_result;
        end
    end

endmodule

FILE: hdl/x86_16_instruction_length_decoder_core.sv
// Splits a stream of 16-bit x86 code bytes into instructions. One code byte is taken per
// clock unless the four-entry queue is full; each finished instruction (or a partial one cut
// off by end of code) yields one result word carrying its start offset, opcode, ModRM,
// displacement, immediate, far segment, length, operand class and branch target. Input runs at
// one byte per cycle unless that queue is full, so results never outpace input. A result word
// reaches the output register by way of the queue: the byte-tracking front end writes it into
// the queue as its final byte is taken, and the field extractor then loads it into the output
// register. Input stalls only when that queue is full.
module x86_16_instruction_length_decoder_core #(
    parameter int OFFSET_BITS = 16
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               push,
    output logic               full,
    input  logic [7:0]         i_code_byte,
    input  logic               i_end_of_code,
    input  logic               pop,
    output logic               empty,
    output logic [15:0]        o_instr_offset,
    output logic [7:0]         o_opcode,
    output logic [7:0]         o_modrm_byte,
    output logic               o_has_modrm,
    output logic signed [15:0] o_displacement,
    output logic [15:0]        o_immediate,
    output logic [15:0]        o_segment_word,
    output logic [2:0]         o_instr_length,
    output logic [2:0]         o_operand_kind,
    output logic [15:0]        o_branch_target,
    output logic               o_truncated,
    output logic               o_last
);
    import x86ild_pkg::*;

    t_instr  w_front_instr;
    t_instr  w_head;
    t_result w_res;
    logic    w_q_push;
    logic    w_q_full;
    logic    w_q_pop;
    logic    w_q_empty;

    x86ild_front #(
        .OFFSET_BITS (OFFSET_BITS)
    ) u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_push        (push),
        .i_code_byte   (i_code_byte),
        .i_end_of_code (i_end_of_code),
        .i_q_full      (w_q_full),
        .o_q_push      (w_q_push),
        .o_instr       (w_front_instr)
    );

    x86ild_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_q_push),
        .i_data  (w_front_instr),
        .o_full  (w_q_full),
        .i_pop   (w_q_pop),
        .o_data  (w_head),
        .o_empty (w_q_empty)
    );

    x86ild_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_head    (w_head),
        .i_q_empty (w_q_empty),
        .o_q_pop   (w_q_pop),
        .i_pop     (pop),
        .o_empty   (empty),
        .o_result  (w_res)
    );

    assign full            = w_q_full;
    assign o_instr_offset  = w_res.instr_offset;
    assign o_opcode        = w_res.opcode;
    assign o_modrm_byte    = w_res.modrm_byte;
    assign o_has_modrm     = w_res.has_modrm;
    assign o_displacement  = signed'(w_res.displacement);
    assign o_immediate     = w_res.immediate;
    assign o_segment_word  = w_res.segment_word;
    assign o_instr_length  = w_res.instr_length;
    assign o_operand_kind  = w_res.operand_kind;
    assign o_branch_target = w_res.branch_target;
    assign o_truncated     = w_res.truncated;
    assign o_last          = w_res.last;

endmodule

FILE: sim/tb.sv
`timescale 1ns / 100ps

module tb;
    import x86ild_pkg::*;

    localparam int STUCK_LIMIT = 4000;
    localparam int PHASE_BYTES = 660;

    // Tracks the byte stream the way the decoder should and holds the instruction words
    // still owed by the block, oldest first.
    class instr_tracker;
        logic [15:0] next_off;
        logic [7:0]  held [6];
        int          got;
        int          want;
        t_result     pending_instrs [$];
        int          errors;
        int          checked;
        int          cut_short;

        function new();
            next_off  = '0;
            got       = 0;
            want      = 0;
            errors    = 0;
            checked   = 0;
            cut_short = 0;
        endfunction

        function t_kind op_class(input logic [7:0] op, output bit two);
            two = 1'b0;
            if (op < 8'h40) begin
                if (op[2:0] < 3'd4) return KIND_MODRM;
                if (op[2:0] == 3'd4) return KIND_IMM;
                if (op[2:0] == 3'd5) begin
                    two = 1'b1;
                    return KIND_IMM;
                end
                return KIND_NONE;
            end
            if (op < 8'h60) return KIND_NONE;
            if (op < 8'h70) return KIND_UNDEF;
            if (op < 8'h80) return KIND_REL8;
            if (op < 8'h90) return KIND_MODRM;
            if (op == 8'h9A) return KIND_FAR;
            if (op < 8'hA0) return KIND_NONE;
            if (op < 8'hA4) return KIND_ADDR;
            if (op == 8'hA8) return KIND_IMM;
            if (op == 8'hA9) begin
                two = 1'b1;
                return KIND_IMM;
            end
            if (op < 8'hB0) return KIND_NONE;
            if (op < 8'hB8) return KIND_IMM;
            if (op < 8'hC0) begin
                two = 1'b1;
                return KIND_IMM;
            end
            case (op)
                8'hC0, 8'hC1, 8'hC8, 8'hC9, 8'hF1: return KIND_UNDEF;
                8'hC2, 8'hCA: begin
                    two = 1'b1;
                    return KIND_IMM;
                end
                8'hCD, 8'hD4, 8'hD5: return KIND_IMM;
                8'hE8, 8'hE9: return KIND_REL16;
                8'hEA: return KIND_FAR;
                8'hEB: return KIND_REL8;
                8'hF6, 8'hF7, 8'hFE, 8'hFF: return KIND_MODRM;
                default: ;
            endcase
            if (op >= 8'hC4 && op <= 8'hC7) return KIND_MODRM;
            if (op >= 8'hD0 && op <= 8'hD3) return KIND_MODRM;
            if (op >= 8'hD8 && op <= 8'hDF) return KIND_MODRM;
            if (op >= 8'hE0 && op <= 8'hE3) return KIND_REL8;
            if (op >= 8'hE4 && op <= 8'hE7) return KIND_IMM;
            return KIND_NONE;
        endfunction

        // Length known from the opcode alone; ModRM forms grow once the ModRM byte is in.
        function int first_need(input t_kind kind, input bit two);
            case (kind)
                KIND_MODRM:             return 2;
                KIND_IMM:               return two ? 3 : 2;
                KIND_ADDR, KIND_REL16:  return 3;
                KIND_FAR:               return 5;
                KIND_REL8:              return 2;
                default:                return 1;
            endcase
        endfunction

        function int disp_bytes(input logic [7:0] m);
            case (m[7:6])
                2'd0:    return (m[2:0] == 3'd6) ? 2 : 0;
                2'd1:    return 1;
                2'd2:    return 2;
                default: return 0;
            endcase
        endfunction

        function int trailing_imm(input logic [7:0] op, input logic [7:0] m);
            case (op)
                OP_GRP1_IMM8, OP_GRP1_IMM8B, OP_GRP1_SIMM8, OP_MOV_RM8: return 1;
                OP_GRP1_IMM16, OP_MOV_RM16:                             return 2;
                OP_GRP3_RM8:  return (m[5:3] < 3'd2) ? 1 : 0;
                OP_GRP3_RM16: return (m[5:3] < 3'd2) ? 2 : 0;
                default:      return 0;
            endcase
        endfunction

        function void take_byte(input logic [7:0] b, input bit eoc);
            t_kind      kind;
            bit         two;
            logic [7:0] w [8];
            t_result    r;
            int         dl;
            int         il;
            if (got >= 6) got = 0;
            held[got] = b;
            got++;
            next_off++;
            kind = op_class(held[0], two);
            if (got == 1)
                want = first_need(kind, two);
            else if (got == 2 && kind == KIND_MODRM)
                want = 2 + disp_bytes(held[1]) + trailing_imm(held[0], held[1]);
            if (got < want && !eoc) return;

            // Bytes past the cut read as zero.
            for (int i = 0; i < 8; i++) w[i] = (i < got) ? held[i] : 8'h00;
            r = '0;
            r.instr_offset = next_off - 16'(got);
            r.opcode       = w[0];
            r.instr_length = got[2:0];
            r.operand_kind = kind;
            r.truncated    = (got < want);
            r.last         = eoc;
            case (kind)
                KIND_MODRM: begin
                    if (got >= 2) begin
                        r.modrm_byte = w[1];
                        r.has_modrm  = 1'b1;
                        dl = disp_bytes(w[1]);
                        il = trailing_imm(w[0], w[1]);
                        if (dl == 1) r.displacement = {{8{w[2][7]}}, w[2]};
                        else if (dl == 2) r.displacement = {w[3], w[2]};
                        if (il == 2) r.immediate = {w[3 + dl], w[2 + dl]};
                        else if (il == 1) r.immediate = {8'h00, w[2 + dl]};
                    end
                end
                KIND_IMM:   r.immediate = two ? {w[2], w[1]} : {8'h00, w[1]};
                KIND_ADDR:  r.immediate = {w[2], w[1]};
                KIND_REL16: r.displacement = {w[2], w[1]};
                KIND_FAR: begin
                    r.immediate    = {w[2], w[1]};
                    r.segment_word = {w[4], w[3]};
                end
                KIND_REL8:  r.displacement = {{8{w[1][7]}}, w[1]};
                default: ;
            endcase
            if ((kind == KIND_REL16 || kind == KIND_REL8) && !r.truncated)
                r.branch_target = r.instr_offset + 16'(got) + r.displacement;
            pending_instrs.push_back(r);
            if (r.truncated) cut_short++;
            got  = 0;
            want = 0;
            if (eoc) next_off = '0;
        endfunction

        function void check_field(input string name, input logic [15:0] exp_v,
                                  input logic [15:0] got_v);
            if (exp_v !== got_v) begin
                $error("%s: expected 0x%04h, got 0x%04h", name, exp_v, got_v);
                errors++;
            end
        endfunction

        function void check_word(input t_result act);
            t_result e;
            if (pending_instrs.size() == 0) begin
                $error("result word with no instruction pending, opcode 0x%02h", act.opcode);
                errors++;
                return;
            end
            e = pending_instrs.pop_front();
            checked++;
            check_field("instr_offset", e.instr_offset, act.instr_offset);
            check_field("opcode", 16'(e.opcode), 16'(act.opcode));
            check_field("modrm_byte", 16'(e.modrm_byte), 16'(act.modrm_byte));
            check_field("has_modrm", 16'(e.has_modrm), 16'(act.has_modrm));
            check_field("displacement", e.displacement, act.displacement);
            check_field("immediate", e.immediate, act.immediate);
            check_field("segment_word", e.segment_word, act.segment_word);
            check_field("instr_length", 16'(e.instr_length), 16'(act.instr_length));
            check_field("operand_kind", 16'(e.operand_kind), 16'(act.operand_kind));
            check_field("branch_target", e.branch_target, act.branch_target);
            check_field("truncated", 16'(e.truncated), 16'(act.truncated));
            check_field("last", 16'(e.last), 16'(act.last));
        endfunction
    endclass

    logic        i_clk = 1'b0;
    logic        i_rst_n;
    logic        push;
    logic        full;
    logic [7:0]  i_code_byte;
    logic        i_end_of_code;
    logic        pop;
    logic        empty;
    logic [15:0] o_instr_offset;
    logic [7:0]  o_opcode;
    logic [7:0]  o_modrm_byte;
    logic        o_has_modrm;
    logic signed [15:0] o_displacement;
    logic [15:0] o_immediate;
    logic [15:0] o_segment_word;
    logic [2:0]  o_instr_length;
    logic [2:0]  o_operand_kind;
    logic [15:0] o_branch_target;
    logic        o_truncated;
    logic        o_last;

    instr_tracker sb;
    t_result      seen;
    int           send_idle_pct;
    int           recv_idle_pct;
    int           bytes_sent;
    int           regions;
    int           stuck;

    x86_16_instruction_length_decoder_core uut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .push           (push),
        .full           (full),
        .i_code_byte    (i_code_byte),
        .i_end_of_code  (i_end_of_code),
        .pop            (pop),
        .empty          (empty),
        .o_instr_offset (o_instr_offset),
        .o_opcode       (o_opcode),
        .o_modrm_byte   (o_modrm_byte),
        .o_has_modrm    (o_has_modrm),
        .o_displacement (o_displacement),
        .o_immediate    (o_immediate),
        .o_segment_word (o_segment_word),
        .o_instr_length (o_instr_length),
        .o_operand_kind (o_operand_kind),
        .o_branch_target(o_branch_target),
        .o_truncated    (o_truncated),
        .o_last         (o_last)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    task automatic send_byte(input logic [7:0] b, input logic eoc);
        while ($urandom_range(99) < send_idle_pct) begin
            push <= 1'b0;
            @(posedge i_clk);
        end
        push          <= 1'b1;
        i_code_byte   <= b;
        i_end_of_code <= eoc;
        @(posedge i_clk);
        while (full) @(posedge i_clk);
        sb.take_byte(b, eoc);
        bytes_sent++;
        if (eoc) regions++;
    endtask

    // One well-formed instruction with random content; now and then the region ends on it,
    // sometimes cutting it short.
    task automatic send_instr();
        logic [7:0] bytes_q [$];
        logic [7:0] op;
        logic [7:0] m;
        t_kind      kind;
        bit         two;
        int         total;
        int         stop;
        bit         ending;
        op = 8'($urandom_range(255));
        if ($urandom_range(3) == 0) begin
            case ($urandom_range(5))
                0:       op = OP_GRP1_IMM8;
                1:       op = OP_GRP1_IMM16;
                2:       op = OP_GRP1_SIMM8;
                3:       op = OP_MOV_RM16;
                4:       op = OP_GRP3_RM8;
                default: op = OP_GRP3_RM16;
            endcase
        end
        kind = sb.op_class(op, two);
        total = sb.first_need(kind, two);
        bytes_q.push_back(op);
        if (kind == KIND_MODRM) begin
            m = 8'($urandom);
            bytes_q.push_back(m);
            total = 2 + sb.disp_bytes(m) + sb.trailing_imm(op, m);
        end
        while (bytes_q.size() < total) bytes_q.push_back(8'($urandom));
        stop   = total - 1;
        ending = ($urandom_range(29) == 0);
        if (ending && $urandom_range(2) == 0) stop = $urandom_range(total - 1);
        for (int i = 0; i <= stop; i++) send_byte(bytes_q[i], ending && i == stop);
    endtask

    // Hold the sender until every owed word is back.
    task automatic drain();
        push <= 1'b0;
        while (sb.pending_instrs.size() != 0) @(posedge i_clk);
    endtask

    always @(posedge i_clk) begin
        if (pop && !empty) begin
            seen.instr_offset  = o_instr_offset;
            seen.opcode        = o_opcode;
            seen.modrm_byte    = o_modrm_byte;
            seen.has_modrm     = o_has_modrm;
            seen.displacement  = o_displacement;
            seen.immediate     = o_immediate;
            seen.segment_word  = o_segment_word;
            seen.instr_length  = o_instr_length;
            seen.operand_kind  = t_kind'(o_operand_kind);
            seen.branch_target = o_branch_target;
            seen.truncated     = o_truncated;
            seen.last          = o_last;
            sb.check_word(seen);
        end
        pop <= i_rst_n && ($urandom_range(99) >= recv_idle_pct);
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (push && !full) || (pop && !empty))
            stuck <= 0;
        else
            stuck <= stuck + 1;
        if (stuck >= STUCK_LIMIT) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    // Prefix, DB byte, JO back across zero, CALL -1, far CALL, grp1 imm8 with disp8,
    // TEST imm16 with disp16, then a far JMP cut off by end of code.
    logic [7:0] directed_bytes [24] = '{
        8'h26, 8'h60, 8'h70, 8'h80, 8'hE8, 8'hFF, 8'hFF,
        8'h9A, 8'h34, 8'h12, 8'h00, 8'hF0,
        8'h83, 8'h45, 8'h80, 8'hFF,
        8'hF7, 8'h86, 8'h34, 8'h12, 8'hCD, 8'hAB,
        8'hEA, 8'h11
    };

    initial begin
        sb            = new();
        send_idle_pct = 0;
        recv_idle_pct = 50;
        bytes_sent    = 0;
        regions       = 0;
        i_rst_n       <= 1'b0;
        push          <= 1'b0;
        i_code_byte   <= 8'h00;
        i_end_of_code <= 1'b0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        for (int i = 0; i < 24; i++) send_byte(directed_bytes[i], i == 23);
        drain();

        for (int ph = 0; ph < 3; ph++) begin
            case (ph)
                0: begin
                    send_idle_pct = 25;
                    recv_idle_pct = 82;
                end
                1: begin
                    send_idle_pct = 82;
                    recv_idle_pct = 25;
                end
                default: begin
                    send_idle_pct = 0;
                    recv_idle_pct = 0;
                end
            endcase
            while (bytes_sent < 24 + (ph + 1) * PHASE_BYTES) send_instr();
            drain();
        end

        repeat (20) @(posedge i_clk);
        if (sb.pending_instrs.size() != 0) begin
            $error("%0d instruction words never came out", sb.pending_instrs.size());
            sb.errors++;
        end
        $display("Streamed %0d code bytes over %0d ended regions under three stall mixes.",
                 bytes_sent, regions);
        $display("Checked %0d instruction words, %0d of them cut short by end of code.",
                 sb.checked, sb.cut_short);
        if (sb.errors == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
